// File: rtl/core/rne_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Roman numeral encoder package
// Widths, character codes and the greedy token table shared by the encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

   localparam int VALUE_W = 12;
   localparam int SYM_W   = 7;

   // Largest value that has a Roman numeral in this block.
   localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(3999);

   // ASCII codes of the characters that the block emits.
   localparam logic [SYM_W-1:0] CHAR_M    = 7'h4D;
   localparam logic [SYM_W-1:0] CHAR_D    = 7'h44;
   localparam logic [SYM_W-1:0] CHAR_C    = 7'h43;
   localparam logic [SYM_W-1:0] CHAR_L    = 7'h4C;
   localparam logic [SYM_W-1:0] CHAR_X    = 7'h58;
   localparam logic [SYM_W-1:0] CHAR_V    = 7'h56;
   localparam logic [SYM_W-1:0] CHAR_I    = 7'h49;
   localparam logic [SYM_W-1:0] CHAR_ZERO = 7'h30;
   localparam logic [SYM_W-1:0] CHAR_NONE = 7'h00;

   // Token table: 13 entries, from 1000 down to 1.
   localparam int TOK_COUNT = 13;
   localparam int TOK_IDX_W = $clog2(TOK_COUNT);

   // One greedy token: its weight and one or two characters.
   typedef struct packed {
      logic [VALUE_W-1:0] weight;
      logic [SYM_W-1:0]   first;
      logic [SYM_W-1:0]   second;
      logic               pair;
   } token_type;

   // Result of the shared compare and subtract unit.
   typedef struct packed {
      logic [VALUE_W-1:0] diff;
      logic               ge;
      logic               zero;
   } cmp_sub_type;

   // Token lookup; the final entry also serves unused indexes.
   function automatic token_type get_token(input logic [TOK_IDX_W-1:0] idx);
      token_type tok;
      case (idx)
         4'd0:    tok = '{VALUE_W'(1000), CHAR_M, CHAR_NONE, 1'b0};
         4'd1:    tok = '{VALUE_W'(900),  CHAR_C, CHAR_M,    1'b1};
         4'd2:    tok = '{VALUE_W'(500),  CHAR_D, CHAR_NONE, 1'b0};
         4'd3:    tok = '{VALUE_W'(400),  CHAR_C, CHAR_D,    1'b1};
         4'd4:    tok = '{VALUE_W'(100),  CHAR_C, CHAR_NONE, 1'b0};
         4'd5:    tok = '{VALUE_W'(90),   CHAR_X, CHAR_C,    1'b1};
         4'd6:    tok = '{VALUE_W'(50),   CHAR_L, CHAR_NONE, 1'b0};
         4'd7:    tok = '{VALUE_W'(40),   CHAR_X, CHAR_L,    1'b1};
         4'd8:    tok = '{VALUE_W'(10),   CHAR_X, CHAR_NONE, 1'b0};
         4'd9:    tok = '{VALUE_W'(9),    CHAR_I, CHAR_X,    1'b1};
         4'd10:   tok = '{VALUE_W'(5),    CHAR_V, CHAR_NONE, 1'b0};
         4'd11:   tok = '{VALUE_W'(4),    CHAR_I, CHAR_V,    1'b1};
         default: tok = '{VALUE_W'(1),    CHAR_I, CHAR_NONE, 1'b0};
      endcase
      return tok;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/rne_cmp_sub.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Roman numeral encoder compare and subtract unit
// Shared arithmetic: tests remainder >= weight and forms the difference.
// ----------------------------------------------------------------------------
module rne_cmp_sub
   import rne_pkg::*;
(
   input  wire logic [VALUE_W-1:0] minuend,
   input  wire logic [VALUE_W-1:0] subtrahend,
   output cmp_sub_type             result
);

   logic [VALUE_W:0] wide_diff;

   // One subtraction gives both the difference and the borrow.
   assign wide_diff   = {1'b0, minuend} - {1'b0, subtrahend};
   assign result.diff = wide_diff[VALUE_W-1:0];
   assign result.ge   = ~wide_diff[VALUE_W];
   assign result.zero = (wide_diff[VALUE_W-1:0] == '0);

endmodule
`default_nettype wire

// File: rtl/core/roman_numeral_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Roman numeral encoder
// Converts a 12-bit value into a run of ASCII Roman numeral characters.
// ----------------------------------------------------------------------------
// Usage:
//   A value is transferred at a rising edge with start high and busy low.
//   Each character appears on rsp_symbol for one cycle with rsp_strobe high;
//   rsp_last marks the final character of the run. Zero gives the single
//   character '0'; a value above 3999 gives one result with rsp_out_of_range
//   set and symbol 0.
// Timing:
//   Zero and out-of-range values answer in the next cycle and busy stays low.
//   Otherwise a sequencer walks a 13-entry token table (1000, 900, ... 1)
//   with one shared compare and subtract unit: each cycle either emits a
//   character or moves to the next token, and a two-character token sends
//   its second character from a separate state. The value is first loaded
//   into the remainder register, and the first character shows once the
//   scan reaches a token that fits and its result is registered.
//   A new value may be started in the cycle that shows the last character.
// Reset:
//   Synchronous reset returns to idle and drops rsp_strobe. The receiver
//   cannot stall, so every character is shown exactly once.
// ----------------------------------------------------------------------------
module roman_numeral_encoder
   import rne_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [VALUE_W-1:0] req_value,
   output      logic               rsp_strobe,
   output      logic [SYM_W-1:0]   rsp_symbol,
   output      logic               rsp_last,
   output      logic               rsp_out_of_range
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_EMIT2 = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [VALUE_W-1:0]   rem_ff, rem_in;
   logic [TOK_IDX_W-1:0] idx_ff, idx_in;
   logic                 strobe_ff, strobe_in;
   logic [SYM_W-1:0]     symbol_ff, symbol_in;
   logic                 last_ff, last_in;
   logic                 oor_ff, oor_in;

   token_type   tok;
   cmp_sub_type cs;
   logic        accept;

   // Current token and the shared unit working on the remainder.
   assign tok = get_token(idx_ff);

   rne_cmp_sub u_cmp_sub (
      .minuend    (rem_ff),
      .subtrahend (tok.weight),
      .result     (cs)
   );

   assign accept = start && (state_ff == ST_IDLE);

   // Sequencer: accept a value in idle, then emit or advance each cycle.
   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      strobe_in = 1'b0;
      symbol_in = symbol_ff;
      last_in   = last_ff;
      oor_in    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_value > MAX_VALUE) begin
                  strobe_in = 1'b1;
                  symbol_in = CHAR_NONE;
                  last_in   = 1'b1;
                  oor_in    = 1'b1;
               end else if (req_value == '0) begin
                  strobe_in = 1'b1;
                  symbol_in = CHAR_ZERO;
                  last_in   = 1'b1;
               end else begin
                  rem_in   = req_value;
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (cs.ge) begin
               // The token fits: send its first character.
               rem_in    = cs.diff;
               strobe_in = 1'b1;
               symbol_in = tok.first;
               last_in   = cs.zero && !tok.pair;
               if (tok.pair) begin
                  state_in = ST_EMIT2;
               end else if (cs.zero) begin
                  state_in = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + TOK_IDX_W'(1);
            end
         end
         ST_EMIT2: begin
            // Second character of a subtractive pair.
            strobe_in = 1'b1;
            symbol_in = tok.second;
            last_in   = (rem_ff == '0);
            state_in  = (rem_ff == '0) ? ST_IDLE : ST_SCAN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // Datapath and result registers.
   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      idx_ff    <= idx_in;
      symbol_ff <= symbol_in;
      last_ff   <= last_in;
      oor_ff    <= oor_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_symbol       = symbol_ff;
   assign rsp_last         = last_ff;
   assign rsp_out_of_range = oor_ff;

endmodule
`default_nettype wire

// File: rtl/core/rne_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Roman numeral encoder checker
// Port-level assertions on the encoder, attached by a bind statement.
// ----------------------------------------------------------------------------
module rne_checker
   import rne_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic [VALUE_W-1:0] req_value,
   input wire logic               rsp_strobe,
   input wire logic [SYM_W-1:0]   rsp_symbol,
   input wire logic               rsp_last,
   input wire logic               rsp_out_of_range
);

   // The block only becomes busy because of a transfer.
   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a start transfer");

   // An out-of-range value answers at once with a single flagged result.
   a_oor_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_value > MAX_VALUE) |=>
         (rsp_strobe && rsp_out_of_range && rsp_last && rsp_symbol == CHAR_NONE))
      else $error("out-of-range value not answered correctly");

   // Zero answers at once with the character '0'.
   a_zero_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_value == '0) |=>
         (rsp_strobe && !rsp_out_of_range && rsp_last && rsp_symbol == CHAR_ZERO))
      else $error("zero value not answered correctly");

   // A character that is not the last leaves the block busy with the rest.
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("run ended without a last character");

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (.*);
`default_nettype wire
